### rtl/core/sqvg_pkg.sv
package sqvg_pkg;

  localparam int SINE_DEPTH_LOG2  = 10;
  localparam int SINE_TABLE_DEPTH = 1 << SINE_DEPTH_LOG2;
  localparam int SINE_QTR         = SINE_TABLE_DEPTH / 4;
  localparam int IDX_W            = SINE_DEPTH_LOG2;
  localparam int J_W              = SINE_DEPTH_LOG2 - 1;
  localparam int QTR_SHIFT        = SINE_DEPTH_LOG2 - 2;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam int TEX_DIM_W = 13;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEX_WIDTH  = 2'd0,
    CFG_TEX_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef logic [14:0] sin_lut_t [SINE_QTR+1];

  typedef struct packed {
    logic signed [15:0] sin_v;
    logic signed [15:0] cos_v;
  } trig_t;

  function automatic logic [14:0] sin_entry(input int unsigned j);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          r;
    x    = (64'(j) * HALF_PI_Q30) >> QTR_SHIFT;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + longint'(term);
    if (sum < 0) sum = 0;
    r = (sum + 32768) >>> 16;
    if (r > 16384) r = 16384;
    return r[14:0];
  endfunction

  function automatic sin_lut_t build_sin_lut();
    sin_lut_t t;
    for (int j = 0; j <= SINE_QTR; j++) begin
      t[j] = sin_entry(j);
    end
    return t;
  endfunction

  localparam sin_lut_t SIN_LUT = build_sin_lut();

endpackage

### rtl/core/sqvg_if.sv
interface sqvg_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic signed [15:0] scale_x;
  logic signed [15:0] scale_y;
  logic        [15:0] angle;
  logic signed [23:0] origin_x;
  logic signed [23:0] origin_y;
  logic        [15:0] uv_u;
  logic        [15:0] uv_v;
  logic        [15:0] uv_w;
  logic        [15:0] uv_h;
  logic        [31:0] color;
  modport source (output valid, pos_x, pos_y, scale_x, scale_y, angle, origin_x, origin_y,
                  uv_u, uv_v, uv_w, uv_h, color, input ready);
  modport sink (input valid, pos_x, pos_y, scale_x, scale_y, angle, origin_x, origin_y,
                uv_u, uv_v, uv_w, uv_h, color, output ready);
endinterface

interface sqvg_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vert_x;
  logic signed [31:0] vert_y;
  logic        [16:0] tex_u;
  logic        [16:0] tex_v;
  logic        [31:0] vert_color;
  logic        [1:0]  corner;
  logic               last;
  modport source (output valid, vert_x, vert_y, tex_u, tex_v, vert_color, corner, last,
                  input ready);
  modport sink (input valid, vert_x, vert_y, tex_u, tex_v, vert_color, corner, last,
                output ready);
endinterface

### rtl/core/sqvg_trig.sv
module sqvg_trig
  import sqvg_pkg::*;
(
  input  logic [15:0] angle,
  output trig_t       trig
);

  logic [IDX_W-1:0] idx;
  logic [1:0]       q_s;
  logic [1:0]       q_c;
  logic [J_W-1:0]   r;
  logic [J_W-1:0]   j_s;
  logic [J_W-1:0]   j_c;
  logic [14:0]      m_s;
  logic [14:0]      m_c;

  always_comb begin
    idx = angle[15 -: IDX_W];
    q_s = idx[IDX_W-1 -: 2];
    q_c = q_s + 2'd1;
    r   = J_W'(idx[IDX_W-3:0]);
    j_s = q_s[0] ? J_W'(SINE_QTR) - r : r;
    j_c = q_c[0] ? J_W'(SINE_QTR) - r : r;
    m_s = SIN_LUT[j_s];
    m_c = SIN_LUT[j_c];
    trig.sin_v = q_s[1] ? -$signed({1'b0, m_s}) : $signed({1'b0, m_s});
    trig.cos_v = q_c[1] ? -$signed({1'b0, m_c}) : $signed({1'b0, m_c});
  end

endmodule

### rtl/core/sprite_quad_vertex_gen_unit.sv
// channel | dir | handshake          | moves
// in_     | in  | valid/ready        | one sprite request
// out_    | out | valid/ready        | one corner vertex, four per sprite (TL TR BL BR)
// cfg_    | in  | cfg_we             | texture width/height, index 0/1
// One vertex per cycle while out_ is not stalled, set by the corner sequencer at the front.
// A request passes the front register, then five stages, before its first vertex appears.
// Reset (synchronous, rst_n low) empties every stage and sets both texture sizes to 1.
// A stall on out_ holds the whole pipeline; the next sprite is taken during the fourth corner.
module sprite_quad_vertex_gen_unit
  import sqvg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [TEX_DIM_W-1:0] cfg_wdata,
  sqvg_in_if.sink              in_sprite,
  sqvg_out_if.source           out_vert
);

  logic [TEX_DIM_W-1:0] tex_w_r, tex_h_r;

  logic               f_v_r;
  logic [1:0]         cnt_r;
  logic signed [23:0] f_px_r, f_py_r, f_ox_r, f_oy_r;
  logic signed [15:0] f_scx_r, f_scy_r;
  logic [15:0]        f_ang_r, f_uu_r, f_vv_r, f_uw_r, f_vh_r;
  logic [31:0]        f_col_r;

  logic               adv, in_acc, f_done;
  trig_t              trig;

  logic               v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [1:0]         c1_r, c2_r, c3_r, c4_r, c5_r;
  logic [16:0]        u1_r, u2_r, u3_r, u4_r, u5_r;
  logic [16:0]        t1_r, t2_r, t3_r, t4_r, t5_r;
  logic [31:0]        k1_r, k2_r, k3_r, k4_r, k5_r;

  logic signed [29:0] ax1_r, ay1_r;
  logic signed [23:0] ox1_r, oy1_r;
  logic signed [24:0] opx1_r, opy1_r, opx2_r, opy2_r, opx3_r, opy3_r;
  trig_t              tr1_r, tr2_r;

  logic signed [30:0] dx_nxt, dy_nxt, dx2_r, dy2_r;
  logic signed [46:0] pxc_r, pys_r, pxs_r, pyc_r;
  logic signed [48:0] sx_nxt, sy_nxt, sx4_r, sy4_r;
  logic signed [33:0] qx, qy;
  logic signed [31:0] fx_nxt, fy_nxt, fx5_r, fy5_r;

  sqvg_trig u_trig (
    .angle (f_ang_r),
    .trig  (trig)
  );

  assign adv    = !v5_r || out_vert.ready;
  assign f_done = adv && f_v_r && (cnt_r == 2'd3);
  assign in_sprite.ready = !f_v_r || f_done;
  assign in_acc = in_sprite.valid && in_sprite.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_w_r <= TEX_DIM_W'(1);
      tex_h_r <= TEX_DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_TEX_WIDTH:  tex_w_r <= cfg_wdata;
        CFG_TEX_HEIGHT: tex_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
      cnt_r <= 2'd0;
    end else if (in_acc) begin
      f_v_r <= 1'b1;
      cnt_r <= 2'd0;
    end else if (adv && f_v_r) begin
      cnt_r <= cnt_r + 2'd1;
      if (cnt_r == 2'd3) f_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      f_px_r  <= in_sprite.pos_x;
      f_py_r  <= in_sprite.pos_y;
      f_scx_r <= in_sprite.scale_x;
      f_scy_r <= in_sprite.scale_y;
      f_ang_r <= in_sprite.angle;
      f_ox_r  <= in_sprite.origin_x;
      f_oy_r  <= in_sprite.origin_y;
      f_uu_r  <= in_sprite.uv_u;
      f_vv_r  <= in_sprite.uv_v;
      f_uw_r  <= in_sprite.uv_w;
      f_vh_r  <= in_sprite.uv_h;
      f_col_r <= in_sprite.color;
    end
  end

  always_comb begin
    dx_nxt = (c1_r[0] ? 31'(ax1_r) : -31'(ax1_r)) - (31'(ox1_r) <<< 1);
    dy_nxt = (c1_r[1] ? -31'(ay1_r) : 31'(ay1_r)) - (31'(oy1_r) <<< 1);
    sx_nxt = 49'(pxc_r) - 49'(pys_r) + (49'(opx3_r) <<< 15) + 49'sd16384;
    sy_nxt = 49'(pxs_r) + 49'(pyc_r) + (49'(opy3_r) <<< 15) + 49'sd16384;
    qx = 34'(sx4_r >>> 15);
    qy = 34'(sy4_r >>> 15);
    if (qx > 34'sd2147483647)       fx_nxt = 32'sh7FFFFFFF;
    else if (qx < -34'sd2147483648) fx_nxt = 32'sh80000000;
    else                            fx_nxt = qx[31:0];
    if (qy > 34'sd2147483647)       fy_nxt = 32'sh7FFFFFFF;
    else if (qy < -34'sd2147483648) fy_nxt = 32'sh80000000;
    else                            fy_nxt = qy[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v1_r <= f_v_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_r   <= cnt_r;
      u1_r   <= {1'b0, f_uu_r} + (cnt_r[0] ? {1'b0, f_uw_r} : 17'd0);
      t1_r   <= {1'b0, f_vv_r} + (cnt_r[1] ? {1'b0, f_vh_r} : 17'd0);
      k1_r   <= f_col_r;
      ax1_r  <= 30'(f_scx_r) * 30'($signed({1'b0, tex_w_r}));
      ay1_r  <= 30'(f_scy_r) * 30'($signed({1'b0, tex_h_r}));
      ox1_r  <= f_ox_r;
      oy1_r  <= f_oy_r;
      opx1_r <= 25'(f_ox_r) + 25'(f_px_r);
      opy1_r <= 25'(f_oy_r) + 25'(f_py_r);
      tr1_r  <= trig;

      c2_r   <= c1_r;
      u2_r   <= u1_r;
      t2_r   <= t1_r;
      k2_r   <= k1_r;
      dx2_r  <= dx_nxt;
      dy2_r  <= dy_nxt;
      opx2_r <= opx1_r;
      opy2_r <= opy1_r;
      tr2_r  <= tr1_r;

      c3_r   <= c2_r;
      u3_r   <= u2_r;
      t3_r   <= t2_r;
      k3_r   <= k2_r;
      pxc_r  <= 47'(dx2_r) * 47'(tr2_r.cos_v);
      pys_r  <= 47'(dy2_r) * 47'(tr2_r.sin_v);
      pxs_r  <= 47'(dx2_r) * 47'(tr2_r.sin_v);
      pyc_r  <= 47'(dy2_r) * 47'(tr2_r.cos_v);
      opx3_r <= opx2_r;
      opy3_r <= opy2_r;

      c4_r   <= c3_r;
      u4_r   <= u3_r;
      t4_r   <= t3_r;
      k4_r   <= k3_r;
      sx4_r  <= sx_nxt;
      sy4_r  <= sy_nxt;

      c5_r   <= c4_r;
      u5_r   <= u4_r;
      t5_r   <= t4_r;
      k5_r   <= k4_r;
      fx5_r  <= fx_nxt;
      fy5_r  <= fy_nxt;
    end
  end

  assign out_vert.valid      = v5_r;
  assign out_vert.vert_x     = fx5_r;
  assign out_vert.vert_y     = fy5_r;
  assign out_vert.tex_u      = u5_r;
  assign out_vert.tex_v      = t5_r;
  assign out_vert.vert_color = k5_r;
  assign out_vert.corner     = c5_r;
  assign out_vert.last       = (c5_r == 2'd3);

endmodule

### rtl/core/sqvg_checker.sv
module sqvg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  corner,
  input logic        last,
  input logic [31:0] vert_x
);

  logic [1:0] exp_corner_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_corner_r <= 2'd0;
    end else if (out_valid && out_ready) begin
      exp_corner_r <= exp_corner_r + 2'd1;
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_corner_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> corner == exp_corner_r)
    else $error("corner out of order");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (last == (corner == 2'd3)))
    else $error("last flag wrong");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(vert_x))
    else $error("stalled vertex dropped or changed");

endmodule

bind sprite_quad_vertex_gen_unit sqvg_checker u_sqvg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_vert.valid),
  .out_ready (out_vert.ready),
  .corner    (out_vert.corner),
  .last      (out_vert.last),
  .vert_x    (out_vert.vert_x)
);

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import sqvg_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX2 = CFG_IDX_W'(2);

  typedef struct {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic [15:0] angle;
    logic signed [23:0] origin_x;
    logic signed [23:0] origin_y;
    logic [15:0] uv_u;
    logic [15:0] uv_v;
    logic [15:0] uv_w;
    logic [15:0] uv_h;
    logic [31:0] color;
  } sprite_t;

  typedef struct {
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic [31:0] vert_color;
    logic [1:0] corner;
    logic last;
  } vertex_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [TEX_DIM_W-1:0] cfg_wdata;

  sqvg_in_if in_if();
  sqvg_out_if out_if();

  sprite_quad_vertex_gen_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_sprite(in_if.sink),
    .out_vert(out_if.source)
  );

  vertex_t expected_verts[$];
  int fail_count = 0;
  int cycle_count = 0;
  logic [TEX_DIM_W-1:0] tex_w_model;
  logic [TEX_DIM_W-1:0] tex_h_model;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int hold_cnt = 0;
  int sink_gap = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic longint quarter_wave_sin(longint unsigned n, longint unsigned d);
    longint unsigned q, rem, x, x2, term;
    longint acc, r;
    n = n % d;
    q = (n * 4) / d;
    rem = (n * 4) % d;
    if (q[0]) rem = d - rem;
    x = rem * HALF_PI_Q30 / d;
    x2 = (x * x) >> 30;
    term = x;
    acc = longint'(x);
    for (int k = 1; k <= 6; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    r = (acc + 32768) >>> 16;
    if (r > 16384) r = 16384;
    return (q >= 2) ? -r : r;
  endfunction

  function automatic logic signed [31:0] round_sat(longint v);
    longint t;
    t = (v + 16384) >>> 15;
    if (t > 64'sd2147483647) t = 64'sd2147483647;
    if (t < -64'sd2147483648) t = -64'sd2147483648;
    return t[31:0];
  endfunction

  task automatic predict_corners(input sprite_t s);
    longint unsigned idx;
    longint sn, cs, ax, ay, dx, dy, ox, oy, sx, sy;
    vertex_t v;
    idx = (longint'(s.angle) * SINE_TABLE_DEPTH) >> 16;
    sn = quarter_wave_sin(idx, SINE_TABLE_DEPTH);
    cs = quarter_wave_sin(4 * idx + SINE_TABLE_DEPTH, 4 * SINE_TABLE_DEPTH);
    ax = longint'(s.scale_x) * longint'({1'b0, tex_w_model});
    ay = longint'(s.scale_y) * longint'({1'b0, tex_h_model});
    ox = longint'(s.origin_x);
    oy = longint'(s.origin_y);
    for (int k = 0; k < 4; k++) begin
      sx = (k % 2 == 0) ? -1 : 1;
      sy = (k < 2) ? 1 : -1;
      dx = sx * ax - 2 * ox;
      dy = sy * ay - 2 * oy;
      v.vert_x = round_sat(dx * cs - dy * sn + (ox + longint'(s.pos_x)) * 32768);
      v.vert_y = round_sat(dx * sn + dy * cs + (oy + longint'(s.pos_y)) * 32768);
      v.tex_u = {1'b0, s.uv_u} + ((k % 2 == 1) ? {1'b0, s.uv_w} : 17'd0);
      v.tex_v = {1'b0, s.uv_v} + ((k >= 2) ? {1'b0, s.uv_h} : 17'd0);
      v.vert_color = s.color;
      v.corner = k[1:0];
      v.last = (k == 3);
      expected_verts = {expected_verts, v};
    end
  endtask

  always @(posedge clk) begin
    vertex_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_verts.size() == 0) begin
        $error("vertex with nothing expected: x %0d y %0d", out_if.vert_x, out_if.vert_y);
        fail_count++;
      end else begin
        e = expected_verts.pop_front();
        if (out_if.vert_x !== e.vert_x) begin
          $error("vert_x exp %0d got %0d", e.vert_x, out_if.vert_x);
          fail_count++;
        end
        if (out_if.vert_y !== e.vert_y) begin
          $error("vert_y exp %0d got %0d", e.vert_y, out_if.vert_y);
          fail_count++;
        end
        if (out_if.tex_u !== e.tex_u) begin
          $error("tex_u exp %0h got %0h", e.tex_u, out_if.tex_u);
          fail_count++;
        end
        if (out_if.tex_v !== e.tex_v) begin
          $error("tex_v exp %0h got %0h", e.tex_v, out_if.tex_v);
          fail_count++;
        end
        if (out_if.vert_color !== e.vert_color) begin
          $error("vert_color exp %0h got %0h", e.vert_color, out_if.vert_color);
          fail_count++;
        end
        if (out_if.corner !== e.corner) begin
          $error("corner exp %0d got %0d", e.corner, out_if.corner);
          fail_count++;
        end
        if (out_if.last !== e.last) begin
          $error("last exp %0b got %0b", e.last, out_if.last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = LONG_HOLD;
      out_if.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_if.ready <= 1'b0;
    end else if (quiet) begin
      out_if.ready <= 1'b1;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_if.ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0 &&
                 ($urandom_range(0, 3) != 0 || cycle_count % 512 < 256)) begin
      sink_gap = $urandom_range(0, 12);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  task automatic send_sprite(input sprite_t s, input bit typed);
    vertex_t v;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.pos_x <= s.pos_x;
    in_if.pos_y <= s.pos_y;
    in_if.scale_x <= s.scale_x;
    in_if.scale_y <= s.scale_y;
    in_if.angle <= s.angle;
    in_if.origin_x <= s.origin_x;
    in_if.origin_y <= s.origin_y;
    in_if.uv_u <= s.uv_u;
    in_if.uv_v <= s.uv_v;
    in_if.uv_w <= s.uv_w;
    in_if.uv_h <= s.uv_h;
    in_if.color <= s.color;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (typed) begin
      for (int k = 0; k < 4; k++) begin
        v.vert_x = {{8{s.pos_x[23]}}, s.pos_x};
        v.vert_y = {{8{s.pos_y[23]}}, s.pos_y};
        v.tex_u = {1'b0, s.uv_u};
        v.tex_v = {1'b0, s.uv_v};
        v.vert_color = s.color;
        v.corner = k[1:0];
        v.last = (k == 3);
        expected_verts = {expected_verts, v};
      end
    end else begin
      predict_corners(s);
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    wait (expected_verts.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_texture(input logic [TEX_DIM_W-1:0] w, input logic [TEX_DIM_W-1:0] h);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_TEX_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_idx <= CFG_TEX_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_idx <= ($urandom_range(0, 1) != 0) ? CFG_SPARE_IDX : CFG_SPARE_IDX2;
    cfg_wdata <= TEX_DIM_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    tex_w_model = w;
    tex_h_model = h;
  endtask

  function automatic sprite_t mk(int px, int py, int scx, int scy, int ang, int ox, int oy,
                                 int uu, int vv, int uw, int vh, logic [31:0] col);
    sprite_t s;
    s.pos_x = px[23:0];
    s.pos_y = py[23:0];
    s.scale_x = scx[15:0];
    s.scale_y = scy[15:0];
    s.angle = ang[15:0];
    s.origin_x = ox[23:0];
    s.origin_y = oy[23:0];
    s.uv_u = uu[15:0];
    s.uv_v = vv[15:0];
    s.uv_w = uw[15:0];
    s.uv_h = vh[15:0];
    s.color = col;
    return s;
  endfunction

  function automatic sprite_t random_sprite();
    sprite_t s;
    s.pos_x = 24'($urandom);
    s.pos_y = 24'($urandom);
    s.scale_x = 16'($urandom);
    s.scale_y = 16'($urandom);
    s.angle = 16'($urandom);
    s.origin_x = 24'($urandom);
    s.origin_y = 24'($urandom);
    s.uv_u = 16'($urandom);
    s.uv_v = 16'($urandom);
    s.uv_w = 16'($urandom);
    s.uv_h = 16'($urandom);
    s.color = $urandom;
    if ($urandom_range(0, 2) == 0) begin
      s.pos_x = 24'($signed(14'($urandom))) <<< 8;
      s.pos_y = 24'($signed(14'($urandom))) <<< 8;
      s.scale_x = 16'($signed(10'($urandom)));
      s.scale_y = 16'($signed(10'($urandom)));
      s.origin_x = 24'($signed(12'($urandom)));
      s.origin_y = 24'($signed(12'($urandom)));
    end
    return s;
  endfunction

  sprite_t dir_tab[];
  bit dir_typed[];

  initial begin
    logic [TEX_DIM_W-1:0] w, h;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_TEX_WIDTH;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.pos_x = '0;
    in_if.pos_y = '0;
    in_if.scale_x = '0;
    in_if.scale_y = '0;
    in_if.angle = '0;
    in_if.origin_x = '0;
    in_if.origin_y = '0;
    in_if.uv_u = '0;
    in_if.uv_v = '0;
    in_if.uv_w = '0;
    in_if.uv_h = '0;
    in_if.color = '0;
    tex_w_model = TEX_DIM_W'(1);
    tex_h_model = TEX_DIM_W'(1);
    dir_tab = '{
      mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0),
      mk(8388607, 8388607, 0, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF, 0, 0, 32'hFFFFFFFF),
      mk(-8388608, -8388608, 0, 0, 16'h1234, 0, 0, 0, 0, 0, 0, 32'h80000001),
      mk(256, -256, 256, 256, 0, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF, 32'h11223344),
      mk(0, 0, 256, 256, 16'h4000, 0, 0, 100, 200, 300, 400, 32'h55667788),
      mk(0, 0, 256, 256, 16'h8000, 0, 0, 1, 2, 3, 4, 32'hA5A5A5A5),
      mk(0, 0, 256, 256, 16'hC000, 0, 0, 1, 2, 3, 4, 32'h5A5A5A5A),
      mk(0, 0, 256, 256, 16'hFFFF, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0),
      mk(1000, 2000, 32767, 32767, 16'h2000, 0, 0, 0, 0, 0, 0, 32'h1),
      mk(1000, 2000, -32768, -32768, 16'h2000, 0, 0, 0, 0, 0, 0, 32'h2),
      mk(0, 0, -256, 512, 16'h0040, 8388607, -8388608, 0, 0, 0, 0, 32'h3),
      mk(0, 0, 512, -256, 16'h003F, -8388608, 8388607, 0, 0, 0, 0, 32'h4)
    };
    dir_typed = '{1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < dir_tab.size(); i++) send_sprite(dir_tab[i], dir_typed[i]);
    drain();
    set_texture(TEX_DIM_W'(4096), TEX_DIM_W'(4096));
    send_sprite(mk(8388607, 8388607, 32767, 32767, 0, -8388608, -8388608,
                   0, 0, 0, 0, 32'h6), 0);
    send_sprite(mk(-8388608, -8388608, -32768, 32767, 16'h6000, 8388607, 8388607,
                   0, 0, 0, 0, 32'h7), 0);
    send_sprite(mk(0, 0, 32767, -32768, 16'hA000, 0, 0, 0, 0, 0, 0, 32'h8), 0);
    drain();
    set_texture(TEX_DIM_W'(8191), TEX_DIM_W'(8191));
    send_sprite(mk(8388607, -8388608, 32767, -32768, 16'hE000, 8388607, -8388608,
                   0, 0, 0, 0, 32'h9), 0);
    drain();
    set_texture('0, '0);
    send_sprite(mk(1234, -4321, 32767, -32768, 16'h1000, 5, -7, 0, 0, 0, 0, 32'hA), 0);
    send_sprite(random_sprite(), 0);
    drain();

    hold_req = 1'b1;
    for (int i = 0; i < 24; i++) send_sprite(random_sprite(), 0);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin w = TEX_DIM_W'(1); h = TEX_DIM_W'(4096); end
        1: begin w = TEX_DIM_W'(4096); h = TEX_DIM_W'(1); end
        2: begin w = '0; h = TEX_DIM_W'($urandom_range(1, 64)); end
        default: begin
          w = TEX_DIM_W'($urandom_range(1, 4096));
          h = TEX_DIM_W'($urandom_range(1, 4096));
        end
      endcase
      set_texture(w, h);
      for (int i = 0; i < 36; i++) send_sprite(random_sprite(), 0);
      if (phase == 3) begin
        in_if.valid <= 1'b0;
        wait (expected_verts.size() == 0);
        @(posedge clk);
      end
      drain();
    end

    set_texture(TEX_DIM_W'($urandom_range(1, 256)), TEX_DIM_W'($urandom_range(1, 256)));
    quiet = 1'b1;
    for (int i = 0; i < 40; i++) send_sprite(random_sprite(), 0);
    in_if.valid <= 1'b0;
    wait (expected_verts.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/sqvg_pkg.sv
rtl/core/sqvg_if.sv
rtl/core/sqvg_trig.sv
rtl/core/sprite_quad_vertex_gen_unit.sv
rtl/core/sqvg_checker.sv
bench/testbench.sv
